[rtl/core/fcd_pkg.sv]
// ----------------------------------------------------------------------------
// fcd_pkg: shared types and constants of the core dispatcher
// Field widths, result codes, register map and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package fcd_pkg;

	// Fixed field widths
	localparam int TAG_W      = 16;
	localparam int CORE_IN_W  = 6;
	localparam int CORE_OUT_W = 4;
	localparam int DEST_W     = 2;
	localparam int CFG_W      = 5;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 3;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Input kind
	localparam logic FUNC_DONE = 1'b1;

	// Result destinations
	localparam logic [DEST_W-1:0] DEST_CORE   = 2'd0;
	localparam logic [DEST_W-1:0] DEST_APP    = 2'd1;
	localparam logic [DEST_W-1:0] DEST_REJECT = 2'd2;

	// Register map: word index taken from paddr[2]
	localparam logic REG_CORES_IN_USE = 1'b0;
	localparam logic [CFG_W-1:0] CORES_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_POP,
		ST_RESP
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_DISPATCH,
		OP_REJECT,
		OP_PUSH,
		OP_RESP_ERR,
		OP_RESP_FREE,
		OP_POP,
		OP_EMIT_POPPED,
		OP_EMIT_RESP
	} op_t;

	typedef struct packed {
		logic load_in;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic is_done;
		logic core_found;
		logic q_full;
		logic q_nonempty;
		logic core_ok;
		logic out_free;
	} stat_t;

endpackage

[rtl/core/fifo_core_dispatcher.sv]
// Sequence: a transaction is accepted in the idle state and evaluated in the evaluate state,
// which loads its result into the result register unless the tag is queued; a completion that
// pops a waiting tag reads the queue there, then hands out the popped dispatch and the response.
// A stalled result register holds the sequencer in place. A new transaction is accepted only
// when the sequencer is back in idle, once the last one is done.
// Reset: every core idle, queue empty, cores_in_use = 16; queue storage is not cleared.
// ----------------------------------------------------------------------------
// fifo_core_dispatcher: work tag dispatcher with idle bitmap and FIFO
// Streams requests and completions in, dispatches tags to idle cores, queues
// or rejects when none is free, and passes completions back as responses.
// ----------------------------------------------------------------------------
module fifo_core_dispatcher #(
	parameter int MAX_CORES   = 16,
	parameter int QUEUE_DEPTH = 64,
	parameter int TAG_BITS    = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [fcd_pkg::IN_DATA_W-1:0]      s_tdata,  // work_tag[15:0], done_core[21:16], pad
	input  logic                               s_tuser,  // func
	// Result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [fcd_pkg::OUT_DATA_W-1:0]     m_tdata,  // core_index[3:0], result_tag[19:4], pad
	output logic [fcd_pkg::OUT_USER_W-1:0]     m_tuser,  // destination[1:0], index_error[2]
	output logic                               m_tlast,
	// Configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [fcd_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [fcd_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [fcd_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import fcd_pkg::*;

	logic [CFG_W-1:0]      cores_in_use_q;
	cmd_t                  cmd;
	stat_t                 stat;
	logic [DEST_W-1:0]     out_dest;
	logic [CORE_OUT_W-1:0] out_core;
	logic [TAG_W-1:0]      out_tag;
	logic                  out_err;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cores_in_use_q <= CORES_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CORES_IN_USE)) begin
			cores_in_use_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CORES_IN_USE) ? APB_DATA_W'(cores_in_use_q) : '0;

	fcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fcd_datapath #(
		.MAX_CORES   (MAX_CORES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cores_in_use (cores_in_use_q),
		.cmd          (cmd),
		.stat         (stat),
		.in_func      (s_tuser),
		.in_tag       (s_tdata[15:0]),
		.in_core      (s_tdata[21:16]),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_dest     (out_dest),
		.out_core     (out_core),
		.out_tag      (out_tag),
		.out_err      (out_err),
		.out_last     (m_tlast)
	);

	// Result packing
	assign m_tdata = {4'b0000, out_tag, out_core};
	assign m_tuser = {out_err, out_dest};

endmodule

[rtl/core/fcd_ctrl.sv]
// ----------------------------------------------------------------------------
// fcd_ctrl: dispatcher sequencer
// Takes one transaction at a time, picks the operation from the datapath
// status and steps through the pop and the two results of a completion.
// ----------------------------------------------------------------------------
module fcd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fcd_pkg::stat_t stat,
	output fcd_pkg::cmd_t  cmd
);
	import fcd_pkg::*;

	state_t state_q;
	state_t state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_EVAL;
			end
			ST_EVAL: begin
				if (!stat.is_done) begin
					if (stat.core_found || stat.q_full) begin
						if (stat.out_free) state_next = ST_IDLE;
					end else begin
						state_next = ST_IDLE;
					end
				end else if (!stat.core_ok) begin
					if (stat.out_free) state_next = ST_IDLE;
				end else if (stat.q_nonempty) begin
					state_next = ST_POP;
				end else if (stat.out_free) begin
					state_next = ST_IDLE;
				end
			end
			ST_POP: begin
				if (stat.out_free) state_next = ST_RESP;
			end
			ST_RESP: begin
				if (stat.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.load_in = 1'b0;
		cmd.op      = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_EVAL: begin
				if (!stat.is_done) begin
					if (stat.core_found) begin
						if (stat.out_free) cmd.op = OP_DISPATCH;
					end else if (stat.q_full) begin
						if (stat.out_free) cmd.op = OP_REJECT;
					end else begin
						cmd.op = OP_PUSH;
					end
				end else if (!stat.core_ok) begin
					if (stat.out_free) cmd.op = OP_RESP_ERR;
				end else if (stat.q_nonempty) begin
					cmd.op = OP_POP;
				end else if (stat.out_free) begin
					cmd.op = OP_RESP_FREE;
				end
			end
			ST_POP: begin
				if (stat.out_free) cmd.op = OP_EMIT_POPPED;
			end
			ST_RESP: begin
				if (stat.out_free) cmd.op = OP_EMIT_RESP;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

[rtl/core/fcd_datapath.sv]
// ----------------------------------------------------------------------------
// fcd_datapath: idle bitmap, tag queue and result register
// Holds the accepted transaction, finds the lowest idle core, keeps the
// waiting-tag FIFO in a memory and drives the single result register.
// ----------------------------------------------------------------------------
module fcd_datapath #(
	parameter int MAX_CORES   = 16,
	parameter int QUEUE_DEPTH = 64,
	parameter int TAG_BITS    = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [fcd_pkg::CFG_W-1:0]         cores_in_use,
	input  fcd_pkg::cmd_t                     cmd,
	output fcd_pkg::stat_t                    stat,
	input  logic                              in_func,
	input  logic [fcd_pkg::TAG_W-1:0]         in_tag,
	input  logic [fcd_pkg::CORE_IN_W-1:0]     in_core,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [fcd_pkg::DEST_W-1:0]        out_dest,
	output logic [fcd_pkg::CORE_OUT_W-1:0]    out_core,
	output logic [fcd_pkg::TAG_W-1:0]         out_tag,
	output logic                              out_err,
	output logic                              out_last
);
	import fcd_pkg::*;

	localparam int TW   = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam int IW   = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
	localparam int NW   = ($clog2(MAX_CORES + 1) > CORE_IN_W) ?
		$clog2(MAX_CORES + 1) : CORE_IN_W;
	localparam int AW   = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	// Captured transaction
	logic                 func_q;
	logic [TW-1:0]        tag_q;
	logic [CORE_IN_W-1:0] core_q;

	// Core state and queue
	logic [MAX_CORES-1:0] idle_q;
	logic [TW-1:0]        mem [QUEUE_DEPTH];
	logic [TW-1:0]        pop_q;
	logic [AW-1:0]        head_q;
	logic [AW-1:0]        tail_q;
	logic [CNTW-1:0]      count_q;

	// Result register
	logic                  out_valid_q;
	logic [DEST_W-1:0]     out_dest_q;
	logic [CORE_OUT_W-1:0] out_core_q;
	logic [TAG_W-1:0]      out_tag_q;
	logic                  out_err_q;
	logic                  out_last_q;

	logic [NW-1:0] n_act;
	logic          found;
	logic [IW-1:0] found_idx;
	logic [IW-1:0] core_sel;
	logic          emit;

	// Capture the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= in_func;
			tag_q  <= in_tag[TW-1:0];
			core_q <= in_core;
		end
	end

	// Active core count, clamped to the bitmap size
	assign n_act = (NW'(cores_in_use) > NW'(MAX_CORES)) ? NW'(MAX_CORES) : NW'(cores_in_use);
	assign core_sel = core_q[IW-1:0];

	// Lowest idle core below the active count
	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = MAX_CORES - 1; i >= 0; i--) begin
			if (idle_q[i] && (NW'(i) < n_act)) begin
				found     = 1'b1;
				found_idx = IW'(i);
			end
		end
	end

	// Status to the controller
	assign stat.is_done    = (func_q == FUNC_DONE);
	assign stat.core_found = found;
	assign stat.q_full     = (count_q == CNTW'(QUEUE_DEPTH));
	assign stat.q_nonempty = (count_q != '0);
	assign stat.core_ok    = (NW'(core_q) < n_act);
	assign stat.out_free   = !out_valid_q || out_ready;

	// Idle bitmap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= '1;
		end else begin
			case (cmd.op)
				OP_DISPATCH:  idle_q[found_idx] <= 1'b0;
				OP_RESP_FREE: idle_q[core_sel]  <= 1'b1;
				OP_POP:       idle_q[core_sel]  <= 1'b0;
				default:      ;
			endcase
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			case (cmd.op)
				OP_PUSH: begin
					tail_q  <= (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
					count_q <= count_q + 1'b1;
				end
				OP_POP: begin
					head_q  <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
					count_q <= count_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Tag storage: write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (cmd.op == OP_PUSH) mem[tail_q] <= tag_q;
		if (cmd.op == OP_POP) pop_q <= mem[head_q];
	end

	always_comb begin
		case (cmd.op) inside
			OP_DISPATCH, OP_REJECT, OP_RESP_ERR, OP_RESP_FREE,
			OP_EMIT_POPPED, OP_EMIT_RESP: emit = 1'b1;
			default:                      emit = 1'b0;
		endcase
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_DISPATCH: begin
				out_dest_q <= DEST_CORE;
				out_core_q <= CORE_OUT_W'(found_idx);
				out_tag_q  <= TAG_W'(tag_q);
				out_err_q  <= 1'b0;
				out_last_q <= 1'b1;
			end
			OP_REJECT: begin
				out_dest_q <= DEST_REJECT;
				out_core_q <= '0;
				out_tag_q  <= TAG_W'(tag_q);
				out_err_q  <= 1'b0;
				out_last_q <= 1'b1;
			end
			OP_RESP_ERR: begin
				out_dest_q <= DEST_APP;
				out_core_q <= '0;
				out_tag_q  <= TAG_W'(tag_q);
				out_err_q  <= 1'b1;
				out_last_q <= 1'b1;
			end
			OP_RESP_FREE, OP_EMIT_RESP: begin
				out_dest_q <= DEST_APP;
				out_core_q <= CORE_OUT_W'(core_q);
				out_tag_q  <= TAG_W'(tag_q);
				out_err_q  <= 1'b0;
				out_last_q <= 1'b1;
			end
			OP_EMIT_POPPED: begin
				out_dest_q <= DEST_CORE;
				out_core_q <= CORE_OUT_W'(core_q);
				out_tag_q  <= TAG_W'(pop_q);
				out_err_q  <= 1'b0;
				out_last_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_dest  = out_dest_q;
	assign out_core  = out_core_q;
	assign out_tag   = out_tag_q;
	assign out_err   = out_err_q;
	assign out_last  = out_last_q;

	// Fill count never passes the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	// A pop is only issued on a queue that holds a tag
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_POP) |-> (count_q != '0))
		else $error("pop from empty queue");

	// A new result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// A push grows the queue by exactly one
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_PUSH) |=> (count_q == $past(count_q) + 1'b1))
		else $error("push did not advance count");

endmodule
